/* rtl/bcm_pkg.sv */
package bcm_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SCALE,
        CFG_CONN_ENTER,
        CFG_DISC_EXIT,
        CFG_LOW_ENTER,
        CFG_LOW_EXIT,
        CFG_UNBAL_ENTER,
        CFG_UNBAL_EXIT
    } t_cfg_idx;

    typedef enum logic [1:0] {
        ST_SAFE,
        ST_DISC,
        ST_LOW,
        ST_UNBAL
    } t_cell_st;

    typedef struct packed {
        logic [15:0] scale;
        logic [9:0]  conn_enter;
        logic [9:0]  disc_exit;
        logic [14:0] low_enter;
        logic [14:0] low_exit;
        logic [14:0] unbal_enter;
        logic [14:0] unbal_exit;
    } t_cfg;

    localparam logic [15:0] RST_SCALE       = 16'd1250;
    localparam logic [9:0]  RST_CONN_ENTER  = 10'd100;
    localparam logic [9:0]  RST_DISC_EXIT   = 10'd120;
    localparam logic [14:0] RST_LOW_ENTER   = 15'd3300;
    localparam logic [14:0] RST_LOW_EXIT    = 15'd3500;
    localparam logic [14:0] RST_UNBAL_ENTER = 15'd500;
    localparam logic [14:0] RST_UNBAL_EXIT  = 15'd300;

endpackage

/* rtl/bcm_smp_if.sv */
interface bcm_smp_if #(
    parameter int ADC_BITS = 10
);
    logic                valid;
    logic                ready;
    logic [ADC_BITS-1:0] tap0_counts;
    logic [ADC_BITS-1:0] tap1_counts;
    logic [ADC_BITS-1:0] tap2_counts;

    modport source (output valid, output tap0_counts, output tap1_counts,
                    output tap2_counts, input ready);
    modport sink (input valid, input tap0_counts, input tap1_counts,
                  input tap2_counts, output ready);
endinterface

/* rtl/bcm_res_if.sv */
interface bcm_res_if;
    logic              valid;
    logic              ready;
    logic              pack_safe;
    logic              pack_connected;
    logic signed [15:0] cell0_mv;
    logic signed [15:0] cell1_mv;
    logic signed [15:0] cell2_mv;
    logic signed [15:0] total_mv;
    logic [1:0]        cell0_status;
    logic [1:0]        cell1_status;
    logic [1:0]        cell2_status;

    modport source (output valid, output pack_safe, output pack_connected,
                    output cell0_mv, output cell1_mv, output cell2_mv, output total_mv,
                    output cell0_status, output cell1_status, output cell2_status,
                    input ready);
    modport sink (input valid, input pack_safe, input pack_connected,
                  input cell0_mv, input cell1_mv, input cell2_mv, input total_mv,
                  input cell0_status, input cell1_status, input cell2_status,
                  output ready);
endinterface

/* rtl/bcm_cfg_regs.sv */
module bcm_cfg_regs import bcm_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_we,
    input  logic [CFG_IDX_W-1:0]  i_idx,
    input  logic [CFG_DATA_W-1:0] i_data,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.scale       <= RST_SCALE;
            r_cfg.conn_enter  <= RST_CONN_ENTER;
            r_cfg.disc_exit   <= RST_DISC_EXIT;
            r_cfg.low_enter   <= RST_LOW_ENTER;
            r_cfg.low_exit    <= RST_LOW_EXIT;
            r_cfg.unbal_enter <= RST_UNBAL_ENTER;
            r_cfg.unbal_exit  <= RST_UNBAL_EXIT;
        end else if (i_we) begin
            case (t_cfg_idx'(i_idx))
                CFG_SCALE:       r_cfg.scale       <= i_data;
                CFG_CONN_ENTER:  r_cfg.conn_enter  <= i_data[9:0];
                CFG_DISC_EXIT:   r_cfg.disc_exit   <= i_data[9:0];
                CFG_LOW_ENTER:   r_cfg.low_enter   <= i_data[14:0];
                CFG_LOW_EXIT:    r_cfg.low_exit    <= i_data[14:0];
                CFG_UNBAL_ENTER: r_cfg.unbal_enter <= i_data[14:0];
                CFG_UNBAL_EXIT:  r_cfg.unbal_exit  <= i_data[14:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

/* rtl/bcm_scale.sv */
module bcm_scale import bcm_pkg::*; #(
    parameter int ADC_BITS = 10,
    parameter int P_W      = ADC_BITS + 16,
    parameter int C_W      = P_W - 1
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [ADC_BITS-1:0]   i_tap [3],
    input  logic [15:0]           i_scale,
    input  logic                  i_adv,
    output logic                  o_valid,
    output logic [ADC_BITS-1:0]   o_raw [3],
    output logic signed [C_W-1:0] o_c [3]
);

    localparam int    S_W      = P_W + 8;
    localparam int    K        = P_W + 3;
    localparam longint RECIP_L = ((64'sd1 <<< K) + 64'sd4) / 64'sd5;
    localparam longint ZOFF_L  = 64'sd5 * (64'sd1 <<< (P_W - 4));
    localparam logic [P_W:0]           RECIP  = (P_W+1)'(RECIP_L);
    localparam logic signed [S_W-1:0]  Z_OFF  = S_W'(ZOFF_L);
    localparam logic signed [S_W-1:0]  RND0   = S_W'(64);
    localparam logic signed [S_W-1:0]  RND2   = S_W'(1280);
    localparam logic signed [C_W-1:0]  C2_OFF = C_W'(64'sd1 <<< (P_W - 4));

    logic                  r_v1;
    logic [ADC_BITS-1:0]   r_raw1 [3];
    logic [P_W-1:0]        r_p [3];
    logic                  r_v2;
    logic [ADC_BITS-1:0]   r_raw2 [3];
    logic signed [C_W-1:0] r_c [3];

    logic                  en1;
    logic                  en2;
    logic signed [S_W-1:0] e0, e1, e2;
    logic signed [S_W-1:0] a0, a1, y, z, zo;
    logic [2*P_W:0]        prod;
    logic signed [C_W-1:0] n_c [3];

    assign en2     = !r_v2 || i_adv;
    assign en1     = !r_v1 || en2;
    assign o_ready = en1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (en1) begin
                r_v1 <= i_valid;
            end
            if (en2) begin
                r_v2 <= r_v1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1) begin
            for (int i = 0; i < 3; i++) begin
                r_raw1[i] <= i_tap[i];
                r_p[i]    <= P_W'(i_tap[i]) * P_W'(i_scale);
            end
        end
        if (en2) begin
            r_raw2 <= r_raw1;
            r_c    <= n_c;
        end
    end

    // c0 = R(20 p0), c1 = R(40 p1 - 20 p0): the factor 20 cancels into /128.
    // c2 = R(61 p2 - 40 p1): shift by 9, then floor divide by 5 via reciprocal.
    always_comb begin
        e0   = $signed({8'd0, r_p[0]});
        e1   = $signed({8'd0, r_p[1]});
        e2   = $signed({8'd0, r_p[2]});
        a0   = e0 + RND0;
        a1   = (e1 <<< 1) - e0 + RND0;
        y    = (e2 <<< 6) - (e2 <<< 1) - e2 - (e1 <<< 5) - (e1 <<< 3) + RND2;
        z    = y >>> 9;
        zo   = z + Z_OFF;
        prod = (2*P_W+1)'(zo[P_W-1:0]) * (2*P_W+1)'(RECIP);
        n_c[0] = C_W'(a0 >>> 7);
        n_c[1] = C_W'(a1 >>> 7);
        n_c[2] = C_W'(prod[2*P_W:K]) - C2_OFF;
    end

    assign o_valid = r_v2;
    assign o_raw   = r_raw2;
    assign o_c     = r_c;

endmodule

/* rtl/bcm_cell.sv */
module bcm_cell import bcm_pkg::*; #(
    parameter int ADC_BITS = 10
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_load,
    input  logic [ADC_BITS-1:0] i_raw,
    input  logic signed [15:0] i_mv,
    input  logic signed [15:0] i_mv_nxt,
    input  t_cfg               i_cfg,
    output t_cell_st           o_state
);

    localparam int R_W = (ADC_BITS > 10) ? ADC_BITS : 10;

    t_cell_st              r_state;
    t_cell_st              n_state;
    t_cell_st              eval_st;
    logic signed [16:0]    mv17;
    logic signed [16:0]    d;
    logic [16:0]           diff;
    logic                  redo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_SAFE;
        end else if (i_load) begin
            r_state <= n_state;
        end
    end

    always_comb begin
        mv17 = {i_mv[15], i_mv};
        d    = mv17 - {i_mv_nxt[15], i_mv_nxt};
        diff = d[16] ? 17'(-d) : 17'(d);

        if (R_W'(i_raw) < R_W'(i_cfg.conn_enter)) begin
            eval_st = ST_DISC;
        end else if (mv17 < $signed({2'b00, i_cfg.low_enter})) begin
            eval_st = ST_LOW;
        end else if (diff > {2'b00, i_cfg.unbal_enter}) begin
            eval_st = ST_UNBAL;
        end else begin
            eval_st = ST_SAFE;
        end

        case (r_state)
            ST_SAFE:  redo = 1'b1;
            ST_DISC:  redo = R_W'(i_raw) > R_W'(i_cfg.disc_exit);
            ST_LOW:   redo = mv17 > $signed({2'b00, i_cfg.low_exit});
            ST_UNBAL: redo = diff < {2'b00, i_cfg.unbal_exit};
            default:  redo = 1'b1;
        endcase

        n_state = redo ? eval_st : r_state;
    end

    assign o_state = r_state;

endmodule

/* rtl/battery_cell_monitor.sv */
// Stage 1 is the tap-by-scale multiply, stage 2 the divider reciprocal
// multiply, stage 3 the cell state update; a transfer passes them in turn
// to o_res. Throughput: one sample set per cycle unless o_res.ready stalls.
// Reset (synchronous, active low) empties the pipeline, loads the register
// defaults and puts all three cells in the safe state.
module battery_cell_monitor import bcm_pkg::*; #(
    parameter int ADC_BITS = 10
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    bcm_smp_if.sink               i_smp,
    bcm_res_if.source             o_res
);

    localparam int P_W = ADC_BITS + 16;
    localparam int C_W = P_W - 1;
    localparam int T_W = C_W + 2;
    localparam logic signed [T_W-1:0] SAT_HI = T_W'(32767);
    localparam logic signed [T_W-1:0] SAT_LO = T_W'(-32768);

    function automatic logic signed [15:0] sat16(input logic signed [T_W-1:0] v);
        logic signed [15:0] r;
        if (v > SAT_HI) begin
            r = 16'sh7fff;
        end else if (v < SAT_LO) begin
            r = 16'sh8000;
        end else begin
            r = v[15:0];
        end
        return r;
    endfunction

    t_cfg                  w_cfg;
    logic [ADC_BITS-1:0]   w_tap [3];
    logic [ADC_BITS-1:0]   w_raw [3];
    logic signed [C_W-1:0] w_c [3];
    logic signed [15:0]    w_mv [3];
    logic signed [T_W-1:0] w_sum;
    logic                  w_v2;
    logic                  adv;
    logic                  load;
    t_cell_st              w_st [3];

    logic                  r_ov;
    logic signed [15:0]    r_mv [3];
    logic signed [15:0]    r_total;

    bcm_cfg_regs u_cfg (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_we   (i_cfg_we),
        .i_idx  (i_cfg_idx),
        .i_data (i_cfg_data),
        .o_cfg  (w_cfg)
    );

    assign w_tap[0] = i_smp.tap0_counts;
    assign w_tap[1] = i_smp.tap1_counts;
    assign w_tap[2] = i_smp.tap2_counts;

    bcm_scale #(.ADC_BITS(ADC_BITS), .P_W(P_W), .C_W(C_W)) u_scale (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_smp.valid),
        .o_ready(i_smp.ready),
        .i_tap  (w_tap),
        .i_scale(w_cfg.scale),
        .i_adv  (adv),
        .o_valid(w_v2),
        .o_raw  (w_raw),
        .o_c    (w_c)
    );

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_mv[i] = sat16(T_W'(w_c[i]));
        end
        w_sum = T_W'(w_c[0]) + T_W'(w_c[1]) + T_W'(w_c[2]);
    end

    assign adv  = !r_ov || o_res.ready;
    assign load = adv && w_v2;

    for (genvar g = 0; g < 3; g++) begin : g_cell
        bcm_cell #(.ADC_BITS(ADC_BITS)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_load  (load),
            .i_raw   (w_raw[g]),
            .i_mv    (w_mv[g]),
            .i_mv_nxt(w_mv[(g + 1) % 3]),
            .i_cfg   (w_cfg),
            .o_state (w_st[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (adv) begin
            r_ov <= w_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_mv    <= w_mv;
            r_total <= sat16(w_sum);
        end
    end

    assign o_res.valid          = r_ov;
    assign o_res.cell0_mv       = r_mv[0];
    assign o_res.cell1_mv       = r_mv[1];
    assign o_res.cell2_mv       = r_mv[2];
    assign o_res.total_mv       = r_total;
    assign o_res.cell0_status   = w_st[0];
    assign o_res.cell1_status   = w_st[1];
    assign o_res.cell2_status   = w_st[2];
    assign o_res.pack_safe      = (w_st[0] == ST_SAFE) && (w_st[1] == ST_SAFE)
                                  && (w_st[2] == ST_SAFE);
    assign o_res.pack_connected = (w_st[0] != ST_DISC) && (w_st[1] != ST_DISC)
                                  && (w_st[2] != ST_DISC);

`ifndef ASSERT_OFF
    a_state_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && !o_res.ready) |=> ($stable(w_st[0]) && $stable(w_st[1]) && $stable(w_st[2])))
        else $error("cell state changed while result stalled");

    a_no_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_v2 && !r_ov) |=> r_ov)
        else $error("stage 2 result not moved to output");

    a_safe_conn: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.pack_safe |-> o_res.pack_connected)
        else $error("pack safe while a cell is disconnected");
`endif

endmodule
